// ===== rtl/pba_pkg.sv =====
// Shared types and constants of the page bitmap allocator.
package pba_pkg;

    localparam int ADDR_W  = 52;
    localparam int PAGE_W  = 13;
    localparam int CFG_W   = 52;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic CFG_IDX_BASE    = 1'b0;
    localparam logic CFG_IDX_MANAGED = 1'b1;

    typedef struct packed {
        logic              op;
        logic [PAGE_W-1:0] count;
        logic [ADDR_W-1:0] addr;
    } pba_req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] pages_free;
        logic [ADDR_W-1:0] page_address;
        logic [1:0]        status;
    } pba_resp_t;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [PAGE_W-1:0] raddr;
    } pba_mem_req_t;

endpackage

// ===== rtl/pba_bitmap_ram.sv =====
// One-bit-per-page map memory, one write and one registered read port.
module pba_bitmap_ram
    #(parameter int DEPTH = 4096,
      parameter int AW    = 12)
    (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic          rdata
    );

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pba_engine.sv =====
// Sequencer that clears, scans, marks and frees pages of the map memory.
module pba_engine
    import pba_pkg::*;
    #(parameter int DEPTH      = 4096,
      parameter int AW         = 12,
      parameter int PAGE_SHIFT = 12)
    (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear_req,
    input  logic [PAGE_W-1:0] total,
    input  logic [ADDR_W-1:0] base,
    input  logic              start,
    input  pba_req_t          req,
    output logic              idle,
    output logic              resp_valid,
    input  logic              resp_ready,
    output pba_resp_t         resp,
    output pba_mem_req_t      mem,
    input  logic              rdata
    );

    localparam int PGW = ADDR_W - PAGE_SHIFT;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_PREP  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_MARK  = 7'b0010000,
        S_FREE  = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    pba_req_t          req_reg, req_next;
    logic [PAGE_W-1:0] hint_reg, hint_next;
    logic [PAGE_W-1:0] free_reg, free_next;
    logic [PAGE_W-1:0] start_reg, start_next;
    logic              pass_reg, pass_next;
    logic [PAGE_W-1:0] hi_reg, hi_next;
    logic [PAGE_W-1:0] rd_reg, rd_next;
    logic [PAGE_W-1:0] chk_reg, chk_next;
    logic              chkv_reg, chkv_next;
    logic [PAGE_W-1:0] run_reg, run_next;
    logic [PAGE_W-1:0] idx_reg, idx_next;
    logic [PAGE_W-1:0] mptr_reg, mptr_next;
    logic [PAGE_W-1:0] left_reg, left_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [1:0]        status_reg, status_next;
    logic [ADDR_W-1:0] paddr_reg, paddr_next;

    logic [PAGE_W-1:0] lo, hi;
    logic [ADDR_W-1:0] off;
    logic [PGW-1:0]    pg;
    logic [PAGE_W:0]   fsum, hsum;
    logic [PAGE_W-1:0] run_inc;

    assign lo      = pass_reg ? '0 : start_reg;
    assign hi      = pass_reg ? start_reg : total;
    assign off     = req_reg.addr - base;
    assign pg      = off[ADDR_W-1:PAGE_SHIFT];
    assign fsum    = {1'b0, pg[PAGE_W-1:0]} + {1'b0, req_reg.count};
    assign hsum    = {1'b0, idx_reg} + {1'b0, req_reg.count};
    assign run_inc = run_reg + 1'b1;

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        hint_next   = hint_reg;
        free_next   = free_reg;
        start_next  = start_reg;
        pass_next   = pass_reg;
        hi_next     = hi_reg;
        rd_next     = rd_reg;
        chk_next    = chk_reg;
        chkv_next   = 1'b0;
        run_next    = run_reg;
        idx_next    = idx_reg;
        mptr_next   = mptr_reg;
        left_next   = left_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        paddr_next  = paddr_reg;
        mem         = '0;

        case (state_reg)
            S_CLEAR: begin
                mem.we    = 1'b1;
                mem.waddr = PAGE_W'(clr_reg);
                mem.wdata = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    req_next    = req;
                    start_next  = (hint_reg >= total) ? '0 : hint_reg;
                    pass_next   = 1'b0;
                    status_next = ST_DONE;
                    paddr_next  = '0;
                    state_next  = S_PREP;
                end
            end
            S_PREP: begin
                if (req_reg.op == OP_FREE) begin
                    if (req_reg.addr < base || pg >= PGW'(total)) begin
                        status_next = ST_INVALID;
                        state_next  = S_RESP;
                    end else begin
                        if (pg[PAGE_W-1:0] < hint_reg) begin
                            hint_next = pg[PAGE_W-1:0];
                        end
                        hi_next    = (fsum > {1'b0, total}) ? total : fsum[PAGE_W-1:0];
                        rd_next    = pg[PAGE_W-1:0];
                        state_next = S_FREE;
                    end
                end else if (req_reg.count == '0) begin
                    status_next = ST_INVALID;
                    state_next  = S_RESP;
                end else if (req_reg.count > total || (pass_reg && start_reg == '0)) begin
                    status_next = ST_NOFIT;
                    state_next  = S_RESP;
                end else if (req_reg.count > hi - lo) begin
                    // This range cannot hold the run; try the range below the hint.
                    if (pass_reg) begin
                        status_next = ST_NOFIT;
                        state_next  = S_RESP;
                    end else begin
                        pass_next = 1'b1;
                    end
                end else begin
                    hi_next    = hi;
                    rd_next    = lo;
                    run_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads are issued one page ahead of the run check.
                if (rd_reg < hi_reg) begin
                    mem.re    = 1'b1;
                    mem.raddr = rd_reg;
                    rd_next   = rd_reg + 1'b1;
                    chkv_next = 1'b1;
                    chk_next  = rd_reg;
                end
                if (chkv_reg) begin
                    if (!rdata) begin
                        run_next = run_inc;
                    end else begin
                        run_next = '0;
                    end
                    if (!rdata && run_inc == req_reg.count) begin
                        idx_next   = chk_reg + 1'b1 - req_reg.count;
                        mptr_next  = chk_reg + 1'b1 - req_reg.count;
                        left_next  = req_reg.count;
                        chkv_next  = 1'b0;
                        state_next = S_MARK;
                    end else if (chk_reg == hi_reg - 1'b1) begin
                        chkv_next = 1'b0;
                        if (pass_reg) begin
                            status_next = ST_NOFIT;
                            state_next  = S_RESP;
                        end else begin
                            pass_next  = 1'b1;
                            state_next = S_PREP;
                        end
                    end
                end
            end
            S_MARK: begin
                mem.we    = 1'b1;
                mem.waddr = mptr_reg;
                mem.wdata = 1'b1;
                mptr_next = mptr_reg + 1'b1;
                left_next = left_reg - 1'b1;
                if (left_reg == PAGE_W'(1)) begin
                    free_next  = free_reg - req_reg.count;
                    hint_next  = (hsum >= {1'b0, total}) ? '0 : hsum[PAGE_W-1:0];
                    paddr_next = base + (ADDR_W'(idx_reg) << PAGE_SHIFT);
                    state_next = S_RESP;
                end
            end
            S_FREE: begin
                if (rd_reg < hi_reg) begin
                    mem.re    = 1'b1;
                    mem.raddr = rd_reg;
                    rd_next   = rd_reg + 1'b1;
                    chkv_next = 1'b1;
                    chk_next  = rd_reg;
                end
                if (chkv_reg && rdata) begin
                    mem.we    = 1'b1;
                    mem.waddr = chk_reg;
                    mem.wdata = 1'b0;
                    free_next = free_reg + 1'b1;
                end
                if (!(rd_reg < hi_reg) && !chkv_reg) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (resp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase

        if (clear_req) begin
            state_next = S_CLEAR;
            clr_next   = '0;
            hint_next  = '0;
            free_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            hint_reg  <= '0;
            free_reg  <= '0;
            chkv_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hint_reg  <= hint_next;
            free_reg  <= free_next;
            chkv_reg  <= chkv_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        start_reg  <= start_next;
        pass_reg   <= pass_next;
        hi_reg     <= hi_next;
        rd_reg     <= rd_next;
        chk_reg    <= chk_next;
        run_reg    <= run_next;
        idx_reg    <= idx_next;
        mptr_reg   <= mptr_next;
        left_reg   <= left_next;
        status_reg <= status_next;
        paddr_reg  <= paddr_next;
    end

    assign idle              = (state_reg == S_IDLE);
    assign resp_valid        = (state_reg == S_RESP);
    assign resp.status       = status_reg;
    assign resp.page_address = paddr_reg;
    assign resp.pages_free   = free_reg;

endmodule

// ===== rtl/page_bitmap_allocator_core.sv =====
// Top level of the page bitmap allocator: ports, configuration and output register.
//
// The slave channel takes one request word: allocate a run of contiguous pages
// or free a run starting at a physical address. The master channel returns one
// word per request with the status, the allocated address and the free count.
// Registers are written through cfg_wen / cfg_index / cfg_wdata; the user
// must write them only while idle, which the block itself does not enforce:
// index 0 is the base address, index 1 the number of managed pages.
// An allocate reads the map one page per cycle from the next-fit hint and
// wraps below the hint when the search above it fails. The single read
// port of the map memory sets this rate.
// Invalid or impossible requests finish without a scan of the map.
// After reset, and after every write of the managed page count, the whole map
// is set to used in a sweep over min(NUM_PAGES, 8191) entries during which no
// request is taken; software then frees the usable regions.
// One request is in work at a time. The result sits in an output register,
// so the next request is taken while that word waits for m_tready; a stalled
// receiver holds off a further result, and s_tready stays low meanwhile.
module page_bitmap_allocator_core
    import pba_pkg::*;
    #(parameter int NUM_PAGES  = 4096,
      parameter int PAGE_BYTES = 4096)
    (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [71:0]      s_tdata,   // operation, run_pages, free_address
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,   // status, page_address, pages_free
    input  logic             cfg_wen,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
    );

    localparam int DEPTH      = (NUM_PAGES < 8191) ? NUM_PAGES : 8191;
    localparam int AW         = $clog2(DEPTH);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    logic [ADDR_W-1:0] base_reg;
    logic [PAGE_W-1:0] managed_reg;
    logic [PAGE_W-1:0] total;
    logic              clear_req;
    logic              eng_idle, resp_valid, resp_ready, rdata;
    pba_req_t          req;
    pba_resp_t         resp;
    pba_mem_req_t      mem;
    logic              m_tvalid_reg;
    logic [71:0]       m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            managed_reg <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_IDX_BASE:    base_reg    <= cfg_wdata;
                CFG_IDX_MANAGED: managed_reg <= cfg_wdata[PAGE_W-1:0];
                default:         base_reg    <= base_reg;
            endcase
        end
    end

    assign clear_req = cfg_wen && (cfg_index == CFG_IDX_MANAGED);
    assign total     = (DEPTH == 8191 || managed_reg < PAGE_W'(DEPTH))
                       ? managed_reg : PAGE_W'(DEPTH);

    assign req.op    = s_tdata[0];
    assign req.count = s_tdata[13:1];
    assign req.addr  = s_tdata[65:14];

    assign s_tready   = eng_idle;
    assign resp_ready = !m_tvalid_reg || m_tready;

    pba_engine #(
        .DEPTH      (DEPTH),
        .AW         (AW),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_req  (clear_req),
        .total      (total),
        .base       (base_reg),
        .start      (s_tvalid && s_tready),
        .req        (req),
        .idle       (eng_idle),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp),
        .mem        (mem),
        .rdata      (rdata)
    );

    pba_bitmap_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .aclk  (aclk),
        .we    (mem.we),
        .waddr (mem.waddr[AW-1:0]),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (resp_valid && resp_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp_valid && resp_ready) begin
            m_tdata_reg <= {5'd0, resp};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The map is never written while a request may be taken.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mem.we)
        else $error("map written while idle");

    // An accepted request keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken twice");

    // A finished result is only handed over when the output word is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(resp_valid && resp_ready))
        else $error("output word overwritten");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the page bitmap allocator core.
`timescale 1ns / 100ps

module testbench;
    import pba_pkg::*;

    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam logic [63:0] MASK52 = (64'd1 << 52) - 64'd1;
    localparam logic [51:0] BASE_TOP = 52'hFFFFF_FFFF_F000;

    typedef struct {
        logic [1:0]  status;
        logic [51:0] page_address;
        logic [12:0] pages_free;
    } alloc_result_t;

    typedef struct {
        logic [51:0] addr;
        int          count;
    } page_run_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [71:0]      s_tdata = '0;   // operation, run_pages, free_address
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [71:0]      m_tdata;        // status, page_address, pages_free
    logic             cfg_wen = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Shadow of the allocator state.
    bit          page_used [NUM_PAGES];
    int          hint;
    logic [12:0] shadow_free;
    logic [51:0] base_addr;
    logic [12:0] managed;

    alloc_result_t expected_results[$];
    page_run_t     held_runs[$];
    int            error_count = 0;
    bit            no_idle = 1'b0;
    int            stall_left = 0;

    page_bitmap_allocator_core #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int effective_pages();
        return (managed < NUM_PAGES) ? int'(managed) : NUM_PAGES;
    endfunction

    function automatic void clear_map();
        foreach (page_used[i]) page_used[i] = 1'b1;
        hint = 0;
        shadow_free = '0;
    endfunction

    // First page of a free run of cnt pages inside [lo, hi), or -1.
    function automatic int find_free_run(int cnt, int lo, int hi);
        int run;
        run = 0;
        if (cnt == 0 || lo >= hi || cnt > hi - lo) return -1;
        for (int i = lo; i < hi; i++) begin
            if (page_used[i]) begin
                run = 0;
            end else begin
                run++;
                if (run == cnt) return i + 1 - cnt;
            end
        end
        return -1;
    endfunction

    function automatic alloc_result_t predict_allocator(logic op, logic [12:0] count,
                                                        logic [51:0] addr);
        alloc_result_t r;
        int total, start, idx, first;
        logic [63:0] top;
        total = effective_pages();
        r.status = ST_DONE;
        r.page_address = '0;
        if (op == OP_ALLOC) begin
            if (count == 0) begin
                r.status = ST_INVALID;
            end else if (count > total) begin
                r.status = ST_NOFIT;
            end else begin
                start = (hint >= total) ? 0 : hint;
                idx = find_free_run(count, start, total);
                if (idx < 0 && start != 0) idx = find_free_run(count, 0, start);
                if (idx < 0) begin
                    r.status = ST_NOFIT;
                end else begin
                    for (int i = 0; i < count; i++) page_used[idx + i] = 1'b1;
                    shadow_free = shadow_free - count;
                    hint = idx + count;
                    if (hint >= total) hint = 0;
                    r.page_address = 52'((64'(base_addr) + 64'(idx) * PAGE_BYTES) & MASK52);
                end
            end
        end else begin
            top = 64'(base_addr) + 64'(total) * PAGE_BYTES;
            if (addr < base_addr || 64'(addr) >= top) begin
                r.status = ST_INVALID;
            end else begin
                first = int'((addr - base_addr) / PAGE_BYTES);
                for (int i = 0; i < count; i++) begin
                    if (first + i < total && page_used[first + i]) begin
                        page_used[first + i] = 1'b0;
                        shadow_free = shadow_free + 1;
                    end
                end
                if (first < hint) hint = first;
            end
        end
        r.pages_free = shadow_free;
        return r;
    endfunction

    // Receiver: random stall bursts, none while no_idle is set.
    always @(posedge aclk) begin
        if (no_idle) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                alloc_result_t e;
                e = expected_results.pop_front();
                if (m_tdata[1:0] !== e.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tdata[1:0], e.status));
                if (m_tdata[53:2] !== e.page_address)
                    report_mismatch($sformatf("page_address %h, expected %h",
                                              m_tdata[53:2], e.page_address));
                if (m_tdata[66:54] !== e.pages_free)
                    report_mismatch($sformatf("pages_free %0d, expected %0d",
                                              m_tdata[66:54], e.pages_free));
            end
        end
    end

    task automatic send_request(input logic op, input logic [12:0] count,
                                input logic [51:0] addr);
        alloc_result_t r;
        int gap;
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, addr, count, op};
        do @(posedge aclk); while (!s_tready);
        r = predict_allocator(op, count, addr);
        expected_results.push_back(r);
        if (op == OP_ALLOC && r.status == ST_DONE) begin
            page_run_t pr;
            pr.addr = r.page_address;
            pr.count = count;
            held_runs.push_back(pr);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_config(input logic idx, input logic [51:0] value);
        wait_idle();
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (idx == CFG_IDX_BASE) begin
            base_addr = value;
        end else begin
            managed = value[12:0];
            clear_map();
            held_runs.delete();
        end
    endtask

    task automatic test_directed();
        logic [51:0] b;
        b = 52'h12345000;
        write_config(CFG_IDX_BASE, b);
        write_config(CFG_IDX_MANAGED, 52'd16);
        send_request(OP_ALLOC, 13'd1, '0);            // map is all used after setup
        send_request(OP_FREE, 13'd16, b);
        send_request(OP_ALLOC, 13'd0, '1);            // zero pages
        send_request(OP_ALLOC, 13'd17, '0);           // larger than the range
        send_request(OP_ALLOC, 13'd4096, '0);
        send_request(OP_ALLOC, 13'd4, '0);
        send_request(OP_ALLOC, 13'd5, '0);
        send_request(OP_ALLOC, 13'd7, '0);            // hint wraps to page 0
        send_request(OP_FREE, 13'd2, b + 4 * PAGE_BYTES + 123);  // unaligned
        send_request(OP_ALLOC, 13'd3, '0);            // fits neither above nor below
        send_request(OP_ALLOC, 13'd2, '0);
        send_request(OP_FREE, 13'd1, b - 1);
        send_request(OP_FREE, 13'd1, b + 16 * PAGE_BYTES);
        send_request(OP_FREE, 13'd4096, b + 15 * PAGE_BYTES);    // runs past the end
        send_request(OP_FREE, 13'd3, b + 15 * PAGE_BYTES);       // already free
        send_request(OP_FREE, 13'd0, b + 8 * PAGE_BYTES);        // frees nothing and leaves the hint
        send_request(OP_ALLOC, 13'd1, '0);
        send_request(OP_FREE, 13'd16, b);
        send_request(OP_ALLOC, 13'd16, '0);
        write_config(CFG_IDX_MANAGED, 52'd0);
        send_request(OP_ALLOC, 13'd1, '0);
        send_request(OP_FREE, 13'd1, b);
    endtask

    task automatic test_random(input int pages, input logic [51:0] b, input int items,
                               input int max_count);
        int total, pick, k;
        logic [12:0] cnt;
        write_config(CFG_IDX_BASE, b);
        write_config(CFG_IDX_MANAGED, 52'(pages));
        total = effective_pages();
        if (total > 0) send_request(OP_FREE, 13'(total), b);
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                cnt = 13'($urandom_range(1, max_count));
                send_request(OP_ALLOC, cnt, 52'($urandom));
            end else if (pick < 85 && held_runs.size() != 0) begin
                k = $urandom_range(0, held_runs.size() - 1);
                send_request(OP_FREE, 13'(held_runs[k].count),
                             held_runs[k].addr + 52'($urandom_range(0, PAGE_BYTES - 1)));
                held_runs.delete(k);
            end else if (pick < 92 && total > 0) begin
                // In-range free of a random span, which may be partly free already.
                send_request(OP_FREE, 13'($urandom_range(0, max_count)),
                             b + 52'($urandom_range(0, total - 1)) * PAGE_BYTES);
            end else begin
                cnt = 13'($urandom_range(0, 8191));
                send_request(logic'($urandom_range(0, 1)), ($urandom_range(0, 1)) ? cnt : '0,
                             52'({$urandom, $urandom}));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        base_addr = '0;
        managed = '0;
        clear_map();
        test_directed();
        test_random(64, 52'd0, 560, 12);
        test_random(200, BASE_TOP - 52'd199 * PAGE_BYTES, 450, 30);
        test_random(1, BASE_TOP, 80, 2);
        test_random(8191, BASE_TOP, 30, 4096);
        test_random(4096, 52'h00ABC_DEF0_1000, 40, 600);
        test_random(0, 52'h5555_5555_5000, 40, 4);
        no_idle = 1'b1;
        test_random(37, 52'hA_AAAA_AAAA_A000, 700, 9);
        wait_idle();
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
